// ===== sv/oss_pkg.sv =====
`timescale 1ns / 1ps
// oss_pkg: shared types and constants for the overlapping substring scanner.
// No dependencies; used by every module of the block.
package oss_pkg;

	localparam int PATTERN_W = 64;   // pattern register, 8 bytes
	localparam int LENGTH_W  = 4;    // pattern length register
	localparam int ORDINAL_W = 24;   // running match count
	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 2;    // configuration register index

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [INDEX_W-1:0] REG_LENGTH  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_CASE    = 2'd2;

	// input command codes; code 3 is unused and ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_TEXT  = 2'd0,
		CMD_EOL   = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	// window update request from the top level
	typedef struct packed {
		logic              shift;
		logic              clear;
		logic [BYTE_W-1:0] data;
	} win_ctl_t;

	// pattern setup seen by the compare
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic [LENGTH_W-1:0]  used_len;   // already clamped to 1..PATTERN_MAX
		logic                 match_case;
	} pat_cfg_t;

endpackage

// ===== sv/overlapping_substring_scanner.sv =====
`timescale 1ns / 1ps
// overlapping_substring_scanner: top level, input stage, counters, result register.
// Depends on oss_pkg and oss_window.
//
// Channel  Dir  Signals                        Beat carries
// s_*      in   s_tvalid s_tready s_tdata/user text byte, command
// m_*      out  m_tvalid m_tready m_tdata      line, start column, ordinal
// cfg_*    in   cfg_we cfg_index cfg_data      pattern, length, case flag
//
// One beat per cycle sustained while no result is stalled. Each beat passes
// the input register, then window compare and counters into the result
// register; the 8-byte window compare and counter logic lie in between.
// Reset clears the window, counters and pipeline valids and loads the
// register defaults (length 1, case folding on).
// A stalled result holds the whole pipe; s_tready drops only while a result
// waits and a further beat is already held in the input register.
module overlapping_substring_scanner #(
	parameter int PATTERN_MAX = 8,
	parameter int COLUMN_BITS = 16,
	parameter int LINE_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [oss_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
	input  logic [oss_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// match_line, match_column, match_ordinal, zero pad
	output logic [((LINE_BITS + COLUMN_BITS + oss_pkg::ORDINAL_W + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [oss_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [oss_pkg::PATTERN_W-1:0] cfg_data
);

	localparam int RES_W    = LINE_BITS + COLUMN_BITS + oss_pkg::ORDINAL_W;
	localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [COLUMN_BITS-1:0]         COL_MAX   = '1;
	localparam logic [LINE_BITS-1:0]           LINE_MAX  = '1;
	localparam logic [oss_pkg::ORDINAL_W-1:0]  TOTAL_MAX = '1;

	// configuration registers
	logic [oss_pkg::PATTERN_W-1:0] pattern_q;
	logic [oss_pkg::LENGTH_W-1:0]  length_q;
	logic                          case_q;

	// input stage
	logic                          valid_s1;
	logic [oss_pkg::CMD_W-1:0]     cmd_s1;
	logic [oss_pkg::BYTE_W-1:0]    byte_s1;

	// line state
	logic [COLUMN_BITS-1:0]        fill_q;
	logic [LINE_BITS-1:0]          line_q;
	logic [oss_pkg::ORDINAL_W-1:0] total_q;

	// result register
	logic                          out_valid_q;
	logic [LINE_BITS-1:0]          out_line_q;
	logic [COLUMN_BITS-1:0]        out_col_q;
	logic [oss_pkg::ORDINAL_W-1:0] out_ord_q;

	logic                          advance;
	logic                          do_text;
	logic                          do_eol;
	logic                          do_start;
	logic [oss_pkg::LENGTH_W-1:0]  used_len;
	logic [COLUMN_BITS-1:0]        fill_nx;
	logic [COLUMN_BITS-1:0]        col_nx;
	logic                          win_hit;
	logic                          found;
	oss_pkg::win_ctl_t             win_ctl;
	oss_pkg::pat_cfg_t             pat_cfg;

	// pipe moves whenever the result register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		do_text  = 1'b0;
		do_eol   = 1'b0;
		do_start = 1'b0;
		if (valid_s1 && advance) begin
			case (cmd_s1)
				oss_pkg::CMD_TEXT:  do_text  = 1'b1;
				oss_pkg::CMD_EOL:   do_eol   = 1'b1;
				oss_pkg::CMD_START: do_start = 1'b1;
				default:            ;   // unused code: no effect
			endcase
		end
	end

	// clamp pattern length to 1..PATTERN_MAX
	always_comb begin
		used_len = length_q;
		if (length_q == '0) begin
			used_len = oss_pkg::LENGTH_W'(1);
		end else if (length_q > oss_pkg::LENGTH_W'(PATTERN_MAX)) begin
			used_len = oss_pkg::LENGTH_W'(PATTERN_MAX);
		end
	end

	assign pat_cfg = '{pattern: pattern_q, used_len: used_len, match_case: case_q};
	assign win_ctl = '{shift: do_text, clear: do_eol | do_start, data: byte_s1};

	oss_window #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.cfg    (pat_cfg),
		.hit    (win_hit)
	);

	// column count after this byte, saturating; start column pins at max
	assign fill_nx = (fill_q == COL_MAX) ? fill_q : fill_q + 1'b1;
	assign col_nx  = (fill_nx == COL_MAX) ? COL_MAX
	                                      : fill_nx - COLUMN_BITS'(used_len);
	assign found   = do_text && win_hit && (fill_nx >= COLUMN_BITS'(used_len));

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= oss_pkg::LENGTH_W'(1);
			case_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				oss_pkg::REG_PATTERN: pattern_q <= cfg_data;
				oss_pkg::REG_LENGTH:  length_q  <= cfg_data[oss_pkg::LENGTH_W-1:0];
				oss_pkg::REG_CASE:    case_q    <= cfg_data[0];
				default:              ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// line, column and match counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			line_q  <= '0;
			total_q <= '0;
		end else if (do_start) begin
			fill_q  <= '0;
			line_q  <= '0;
			total_q <= '0;
		end else if (do_eol) begin
			fill_q <= '0;
			if (line_q != LINE_MAX) begin
				line_q <= line_q + 1'b1;
			end
		end else if (do_text) begin
			fill_q <= fill_nx;
			if (found && total_q != TOTAL_MAX) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= found;
		end
	end

	always_ff @(posedge clk) begin
		if (found) begin
			out_line_q <= line_q;
			out_col_q  <= col_nx;
			out_ord_q  <= total_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_ord_q, out_col_q, out_line_q});

endmodule

// ===== sv/oss_window.sv =====
`timescale 1ns / 1ps
// oss_window: byte window of the current line and the parallel pattern compare.
// Depends on oss_pkg.
module oss_window #(
	parameter int PATTERN_MAX = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oss_pkg::win_ctl_t  ctl,
	input  oss_pkg::pat_cfg_t  cfg,
	output logic               hit    // pattern matches the window after this shift
);

	logic [oss_pkg::BYTE_W-1:0] win_q  [PATTERN_MAX];
	logic [oss_pkg::BYTE_W-1:0] win_nx [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]     eq;

	function automatic logic [oss_pkg::BYTE_W-1:0] fold(
		input logic [oss_pkg::BYTE_W-1:0] c,
		input logic                       mc
	);
		logic [oss_pkg::BYTE_W-1:0] r;
		r = c;
		if (!mc && c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	// entry 0 is the newest byte
	always_comb begin
		win_nx[0] = ctl.data;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	// eq[m-1]: the m newest bytes equal the first m pattern bytes
	always_comb begin
		for (int m = 1; m <= PATTERN_MAX; m++) begin
			eq[m-1] = 1'b1;
			for (int k = 0; k < m; k++) begin
				if (fold(cfg.pattern[8*k +: 8], cfg.match_case)
				    != fold(win_nx[m-1-k], cfg.match_case)) begin
					eq[m-1] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int m = 1; m <= PATTERN_MAX; m++) begin
			if (cfg.used_len == oss_pkg::LENGTH_W'(m)) begin
				hit = eq[m-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
		end else if (ctl.clear) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
		end else if (ctl.shift) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_nx[k];
			end
		end
	end

endmodule

// ===== sv/oss_checker.sv =====
`timescale 1ns / 1ps
// oss_checker: port-level checks on the scanner, bound to the top level.
// Depends on oss_pkg and overlapping_substring_scanner.
module oss_checker #(
	parameter int M_DATA_W = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [oss_pkg::CMD_W-1:0]  s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [M_DATA_W-1:0]        m_tdata
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// no result pending right after reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

	// a fresh result comes from an earlier text beat taken through the input register
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |->
			$past(s_tvalid && s_tready && s_tuser == oss_pkg::CMD_TEXT, 2))
		else $error("result without matching text beat");

	// input backpressure only while a result is stuck
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with result side free");

endmodule

bind overlapping_substring_scanner oss_checker #(
	.M_DATA_W (M_DATA_W)
) u_oss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/tb_overlapping_substring_scanner.sv =====
`timescale 1ns / 1ps
// tb_overlapping_substring_scanner: self-checking bench for the substring scanner.
// Depends on oss_pkg and the scanner RTL; predicts every match in a local tracker class.
module tb_overlapping_substring_scanner;

	localparam logic [oss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;   // ignored by the block
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 4;                 // input and result registers plus margin
	localparam int HOLD_CYCLES = 60;                  // long receiver hold-off

	typedef struct packed {
		logic [19:0] line;
		logic [15:0] column;
		logic [23:0] ordinal;
	} match_t;

	// Tracks the document position and the search setup; queues predicted matches.
	class match_tracker;
		logic [oss_pkg::PATTERN_W-1:0] pattern;
		logic [oss_pkg::LENGTH_W-1:0]  length_reg;
		logic                          exact;
		logic [7:0]                    window [8];
		logic [15:0]                   line_fill;
		logic [19:0]                   line_no;
		logic [23:0]                   found;
		match_t                        pending [$];
		int                            errors;

		function new();
			pattern = '0;
			length_reg = 4'd1;
			exact = 1'b0;
			errors = 0;
			line_no = '0;
			found = '0;
			clear_line();
		endfunction

		function void clear_line();
			foreach (window[k]) window[k] = 8'h00;
			line_fill = '0;
		endfunction

		// length register clamped to 1..8
		function int used_len();
			if (length_reg == 0) return 1;
			if (length_reg > 8) return 8;
			return int'(length_reg);
		endfunction

		function logic [7:0] fold(logic [7:0] c);
			if (!exact && c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
			return c;
		endfunction

		function void note_beat(logic [oss_pkg::CMD_W-1:0] cmd, logic [7:0] b);
			int n;
			logic hit;
			match_t m;
			case (cmd)
				oss_pkg::CMD_START: begin
					clear_line();
					line_no = '0;
					found = '0;
				end
				oss_pkg::CMD_EOL: begin
					clear_line();
					if (line_no != '1) line_no++;
				end
				oss_pkg::CMD_TEXT: begin
					for (int k = 7; k > 0; k--) window[k] = window[k-1];
					window[0] = b;
					if (line_fill != '1) line_fill++;
					n = used_len();
					if (line_fill >= n) begin
						hit = 1'b1;
						// pattern char 0 lines up with the oldest byte in use
						for (int k = 0; k < n; k++)
							if (fold(pattern[8*k +: 8]) != fold(window[n-1-k])) hit = 1'b0;
						if (hit) begin
							m.line = line_no;
							m.column = (line_fill == '1) ? '1 : line_fill - 16'(n);
							m.ordinal = found;
							pending = {pending, m};
							if (found != '1) found++;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
			end
		endfunction

		// m_tdata: [19:0] line, [35:20] column, [59:36] ordinal
		function void check_match(logic [63:0] d);
			match_t exp_m;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected match, expected none got line %0d column %0d ordinal %0d",
					$time, d[19:0], d[35:20], d[59:36]);
				return;
			end
			exp_m = pending.pop_front();
			check_field("match_line", exp_m.line, d[19:0]);
			check_field("match_column", exp_m.column, d[35:20]);
			check_field("match_ordinal", exp_m.ordinal, d[59:36]);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [oss_pkg::BYTE_W-1:0]    s_tdata;
	logic [oss_pkg::CMD_W-1:0]     s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [63:0]                   m_tdata;
	logic                          cfg_we;
	logic [oss_pkg::INDEX_W-1:0]   cfg_index;
	logic [oss_pkg::PATTERN_W-1:0] cfg_data;

	match_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_in = 0;        // accepted input beats
	int hold_at = -1;        // beat count that triggers the long hold-off
	int hold_left = 0;
	bit hold_done = 1'b0;    // the long hold-off runs once
	int cycles = 0;

	overlapping_substring_scanner i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang or a missing match ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_overlapping_substring_scanner: errors");
			$finish;
		end
	end

	// Monitor: results first; they always stem from beats taken at earlier edges.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) tracker.check_match(m_tdata);
			if (s_tvalid && s_tready) begin
				tracker.note_beat(s_tuser, s_tdata);
				beats_in++;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once beats_in hits hold_at,
	// so the result register and the input register both fill and s_tready drops.
	always @(negedge clk) begin
		if (!hold_done && hold_left == 0 && beats_in == hold_at) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// One input beat; called and returns at a falling edge. tvalid stays high
	// on return so back-to-back beats never drop it within one step.
	task automatic send_beat(input logic [oss_pkg::CMD_W-1:0] cmd, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(negedge clk);
	endtask

	// Drain, then give the pipe time to finish beats that make no result.
	task automatic end_phase();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [oss_pkg::PATTERN_W-1:0] pat,
			input logic [3:0] len, input logic exact_case);
		cfg_we <= 1'b1;
		cfg_index <= oss_pkg::REG_PATTERN;
		cfg_data <= pat;
		@(negedge clk);
		cfg_index <= oss_pkg::REG_LENGTH;
		cfg_data <= oss_pkg::PATTERN_W'(len);
		@(negedge clk);
		cfg_index <= oss_pkg::REG_CASE;
		cfg_data <= oss_pkg::PATTERN_W'(exact_case);
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.pattern = pat;
		tracker.length_reg = len;
		tracker.exact = exact_case;
	endtask

	// Mostly copies of the pattern (random letter case when folding) and
	// pattern characters, so matches overlap often; the rest is noise.
	task automatic run_random(input int count, input int pause_at);
		int sent;
		int n;
		int r;
		logic [7:0] c;
		sent = 0;
		n = tracker.used_len();
		while (sent < count) begin
			if (pause_at >= 0 && sent >= pause_at) begin
				pause_at = -1;
				wait_drained();
			end
			r = $urandom_range(99);
			if (r < 40) begin
				for (int k = 0; k < n; k++) begin
					c = tracker.pattern[8*k +: 8];
					if (!tracker.exact && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A
							&& $urandom_range(1) == 1)
						c = c ^ 8'h20;
					send_beat(oss_pkg::CMD_TEXT, c);
				end
				sent += n;
			end else if (r < 80) begin
				send_beat(oss_pkg::CMD_TEXT, tracker.pattern[8*$urandom_range(n-1) +: 8]);
				sent++;
			end else if (r < 90) begin
				send_beat(oss_pkg::CMD_TEXT, 8'($urandom_range(255)));
				sent++;
			end else if (r < 96) begin
				send_beat(oss_pkg::CMD_EOL, 8'($urandom_range(255)));
				sent++;
			end else if (r < 98) begin
				send_beat(oss_pkg::CMD_START, 8'($urandom_range(255)));
				sent++;
			end else begin
				// ignored beat, not counted
				send_beat(CMD_UNUSED, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [oss_pkg::PATTERN_W-1:0] pat;
		logic [3:0] len;
		logic [7:0] alpha [4];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = oss_pkg::CMD_TEXT;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = oss_pkg::REG_PATTERN;
		cfg_data = '0;
		alpha[0] = "a";
		alpha[1] = "A";
		alpha[2] = "b";
		alpha[3] = "B";
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: pattern is one 0x00 byte, case folding on.
		send_idle_pct = 26;
		recv_idle_pct = 75;
		send_beat(oss_pkg::CMD_TEXT, 8'h00);
		send_beat(oss_pkg::CMD_TEXT, 8'hFF);
		send_beat(oss_pkg::CMD_TEXT, 8'h00);
		send_beat(CMD_UNUSED, 8'h00);   // must leave column and window alone
		send_beat(oss_pkg::CMD_TEXT, 8'h00);
		send_beat(oss_pkg::CMD_EOL, 8'hFF);
		send_beat(oss_pkg::CMD_TEXT, 8'h00);
		send_beat(oss_pkg::CMD_START, 8'h00);    // counters back to zero
		send_beat(oss_pkg::CMD_TEXT, 8'h00);
		end_phase();

		// "aBa" folded: overlapping hits, no hit across a line end
		apply_settings(64'h0000_0000_0061_4261, 4'd3, 1'b0);
		send_beat(oss_pkg::CMD_TEXT, "A");
		send_beat(oss_pkg::CMD_TEXT, "b");
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "B");
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "b");
		send_beat(oss_pkg::CMD_EOL, 8'h00);
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "b");
		send_beat(CMD_UNUSED, 8'hFF);
		send_beat(oss_pkg::CMD_TEXT, "A");
		end_phase();

		// same pattern, exact case
		apply_settings(64'h0000_0000_0061_4261, 4'd3, 1'b1);
		send_beat(oss_pkg::CMD_TEXT, "A");
		send_beat(oss_pkg::CMD_TEXT, "B");
		send_beat(oss_pkg::CMD_TEXT, "a");
		send_beat(oss_pkg::CMD_TEXT, "B");
		send_beat(oss_pkg::CMD_TEXT, "a");
		end_phase();

		// Random phases: first sender light / receiver heavy idling, then swapped,
		// then none. Phase 5 pauses the sender until drained; phase 9 holds the
		// receiver off long enough to back up the input.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 26;
				recv_idle_pct = 75;
			end else if (ph < 8) begin
				send_idle_pct = 75;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 8; k++)
				pat[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
					: alpha[$urandom_range(3)];
			len = 4'($urandom_range(8, 1));
			case (ph)
				0: apply_settings('1, 4'd8, 1'b1);         // widest pattern, all ones
				1: apply_settings(pat, 4'd0, 1'b0);        // length 0 acts as 1
				2: apply_settings(pat, 4'd15, 1'b1);       // length above 8 acts as 8
				9: apply_settings(pat, 4'd1, 1'b0);        // a match on most beats
				default: apply_settings(pat, len, 1'($urandom_range(1)));
			endcase
			if (ph == 9) hold_at = beats_in + 10;
			run_random(50, (ph == 5) ? 25 : -1);
			end_phase();
		end

		if (tracker.errors == 0)
			$display("tb_overlapping_substring_scanner: clean");
		else
			$display("tb_overlapping_substring_scanner: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/oss_pkg.sv
sv/oss_window.sv
sv/overlapping_substring_scanner.sv
sv/oss_checker.sv
dv/tb_overlapping_substring_scanner.sv
